### hdl/drr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drr_pkg: shared constants and helpers of the deficit round robin scheduler
// Widths, status codes and saturating deficit arithmetic.
// ----------------------------------------------------------------------------
package drr_pkg;

  localparam int NUM_FLOWS     = 4;
  localparam int QUEUE_DEPTH   = 64;
  localparam int QUANTUM_SCALE = 500;

  localparam int FW = $clog2(NUM_FLOWS);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(NUM_FLOWS * QUEUE_DEPTH);
  localparam int MEM_DEPTH = NUM_FLOWS * QUEUE_DEPTH;

  // Gain of one visit: quantum times the scale.
  localparam int GW = $clog2(65535 * QUANTUM_SCALE + 1);
  localparam logic [GW-1:0] GAIN_RESET = GW'(1024 * QUANTUM_SCALE);
  // Visit counts are bounded by 2^31 / scale + 1.
  localparam int KW = $clog2((64'd1 << 31) / QUANTUM_SCALE + 2);
  localparam int PW = KW + GW;
  localparam int DIV_STEPS = 32;

  localparam int NUM_CFG = 5;
  localparam int IW      = $clog2(NUM_CFG);
  localparam logic [IW-1:0] CFG_ACTIVE = IW'(0);
  localparam logic [IW-1:0] CFG_QUANT0 = IW'(1);

  localparam logic [2:0] ST_ENQUEUED  = 3'd0;
  localparam logic [2:0] ST_DROP_UNCL = 3'd1;
  localparam logic [2:0] ST_DROP_FULL = 3'd2;
  localparam logic [2:0] ST_DEQUEUED  = 3'd3;
  localparam logic [2:0] ST_NOTHING   = 3'd4;

  localparam logic OP_ENQUEUE = 1'b0;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] d,
                                                 input logic [PW-1:0] p);
    logic signed [PW+1:0] s;
    s = {{(PW-30){d[31]}}, d} + $signed({2'b00, p});
    if (!s[PW+1] && (|s[PW:31])) begin
      return 32'sh7fffffff;
    end
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] d,
                                                 input logic [15:0] z);
    logic signed [32:0] s;
    s = {d[31], d} - $signed({17'd0, z});
    if (s[32] && !s[31]) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

endpackage
`default_nettype wire

### hdl/deficit_round_robin_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deficit_round_robin_scheduler: DRR scheduler over per-flow size FIFOs
// Sequencer, flow state and descriptor memory around a shared divider.
// ----------------------------------------------------------------------------
// The block takes one item at a time. An enqueue moves from acceptance
// straight to the done state, where its result waits. A dequeue walks the
// active flows: the first walk finds, for every nonempty flow, how many visits
// its deficit needs to turn positive, using the shared 32-step divider for a
// flow whose deficit is not positive. If no flow is nonempty the dequeue ends
// there; otherwise the second walk applies the gains, then the head descriptor
// is read from memory and charged. The result sits in an output register, so
// the next item is taken as soon as the sequencer is back in idle.
module deficit_round_robin_scheduler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [3:0]  flow_id_i,
  input  wire logic [15:0] packet_size_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [1:0]       served_flow_o,
  output logic [15:0]      served_size_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [drr_pkg::IW-1:0]     cfg_index_i,
  input  wire logic [15:0]                cfg_data_i
);

  localparam int FW = drr_pkg::FW;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_READ = 3'd5;
  localparam logic [2:0] S_SUB  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_q;

  // Configuration: the active count and the per-flow gains.
  logic [2:0]             active_q;
  logic [drr_pkg::GW-1:0] gain_q [drr_pkg::NUM_FLOWS];

  // Flow state.
  logic [drr_pkg::CW-1:0] cnt_q  [drr_pkg::NUM_FLOWS];
  logic [drr_pkg::QW-1:0] head_q [drr_pkg::NUM_FLOWS];
  logic signed [31:0]     def_q  [drr_pkg::NUM_FLOWS];
  logic [FW-1:0]          last_q;

  // Walk state.
  logic [FW-1:0]          p_q, f_q, win_q, winpos_q;
  logic [drr_pkg::KW-1:0] best_q;
  logic                   found_q;
  logic [drr_pkg::PW-1:0] prod_q;
  logic [15:0]            rd_q;

  // Pending result and output register.
  logic [2:0]  res_status_q;
  logic [1:0]  res_flow_q;
  logic [15:0] res_size_q;
  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [1:0]  out_flow_q;
  logic [15:0] out_size_q;

  logic [15:0] mem [drr_pkg::MEM_DEPTH];

  // Active flow count clamped to the supported range.
  logic [2:0]    n_used;
  logic [FW-1:0] n_last, f_next, start_flow;

  always_comb begin
    if (active_q == 3'd0) begin
      n_used = 3'd1;
    end else if (active_q > 3'(drr_pkg::NUM_FLOWS)) begin
      n_used = 3'(drr_pkg::NUM_FLOWS);
    end else begin
      n_used = active_q;
    end
  end

  assign n_last = FW'(n_used - 3'd1);
  assign f_next = (f_q == n_last) ? '0 : f_q + FW'(1);

  // The walk starts one past the flow served last, modulo the active count.
  always_comb begin
    logic [FW:0] v;
    v = {1'b0, last_q} + (FW+1)'(1);
    for (int i = 0; i < drr_pkg::NUM_FLOWS; i++) begin
      if (v >= (FW+1)'(n_used)) begin
        v = v - (FW+1)'(n_used);
      end
    end
    start_flow = v[FW-1:0];
  end

  logic [drr_pkg::CW-1:0] cur_cnt;
  logic signed [31:0]     cur_def;
  logic [drr_pkg::GW-1:0] cur_gain;

  assign cur_cnt  = cnt_q[f_q];
  assign cur_def  = def_q[f_q];
  assign cur_gain = gain_q[f_q];

  // Shared divider: visits needed = (-deficit) / gain + 1.
  logic                   div_start, div_done;
  logic [drr_pkg::KW-1:0] div_quo;
  logic [32:0]            neg_def;

  assign neg_def   = 33'd0 - {cur_def[31], cur_def};
  assign div_start = (state_q == S_SCAN) && (cur_cnt != '0) && !(cur_def > 0);

  drr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (neg_def[31:0]),
    .divisor_i  (cur_gain),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Candidate from the current scan step.
  logic                   scan_take, scan_adv, found_n;
  logic [drr_pkg::KW-1:0] scan_k;

  always_comb begin
    scan_adv = 1'b0;
    scan_k   = drr_pkg::KW'(1);
    if (state_q == S_SCAN) begin
      scan_adv = (cur_cnt == '0) || (cur_def > 0);
    end else if (state_q == S_DIV) begin
      scan_adv = div_done;
      scan_k   = div_quo + drr_pkg::KW'(1);
    end
    scan_take = scan_adv && (cur_cnt != '0) && (!found_q || scan_k < best_q);
    found_n   = found_q | scan_take;
  end

  logic [drr_pkg::KW-1:0] visits;
  assign visits = (p_q <= winpos_q) ? best_q : best_q - drr_pkg::KW'(1);

  // Enqueue path.
  logic                   in_acc;
  logic [FW-1:0]          efl;
  logic [drr_pkg::CW:0]   slot_sum;
  logic [drr_pkg::QW-1:0] slot;
  logic                   enq_ok;
  logic [drr_pkg::AW-1:0] waddr, raddr;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign efl      = flow_id_i[FW-1:0];
  assign slot_sum = {1'b0, (drr_pkg::CW)'(head_q[efl])} + {1'b0, cnt_q[efl]};
  assign slot     = (slot_sum >= (drr_pkg::CW+1)'(drr_pkg::QUEUE_DEPTH))
                  ? drr_pkg::QW'(slot_sum - (drr_pkg::CW+1)'(drr_pkg::QUEUE_DEPTH))
                  : drr_pkg::QW'(slot_sum);
  assign enq_ok   = in_acc && (operation_i == drr_pkg::OP_ENQUEUE)
                  && ({1'b0, flow_id_i} < 5'(n_used))
                  && (cnt_q[efl] != drr_pkg::CW'(drr_pkg::QUEUE_DEPTH));
  assign waddr    = drr_pkg::AW'(efl) * drr_pkg::AW'(drr_pkg::QUEUE_DEPTH)
                  + drr_pkg::AW'(slot);
  assign raddr    = drr_pkg::AW'(win_q) * drr_pkg::AW'(drr_pkg::QUEUE_DEPTH)
                  + drr_pkg::AW'(head_q[win_q]);

  always_ff @(posedge clk_i) begin
    if (enq_ok) begin
      mem[waddr] <= packet_size_i;
    end
    if (state_q == S_READ) begin
      rd_q <= mem[raddr];
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 3'd4;
      last_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < drr_pkg::NUM_FLOWS; i++) begin
        gain_q[i] <= drr_pkg::GAIN_RESET;
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
        def_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == drr_pkg::CFG_ACTIVE) begin
          active_q <= cfg_data_i[2:0];
        end
        for (int i = 0; i < drr_pkg::NUM_FLOWS; i++) begin
          if (cfg_index_i == drr_pkg::CFG_QUANT0 + drr_pkg::IW'(i)) begin
            gain_q[i] <= drr_pkg::GW'((cfg_data_i == 16'd0 ? 16'd1 : cfg_data_i)
                                      * drr_pkg::GW'(drr_pkg::QUANTUM_SCALE));
          end
        end
      end

      // A taken result empties the output register unless a new one is loaded.
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      if (scan_take) begin
        best_q   <= scan_k;
        win_q    <= f_q;
        winpos_q <= p_q;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            res_flow_q <= '0;
            res_size_q <= '0;
            if (operation_i == drr_pkg::OP_ENQUEUE) begin
              state_q <= S_DONE;
              if ({1'b0, flow_id_i} >= 5'(n_used)) begin
                res_status_q <= drr_pkg::ST_DROP_UNCL;
              end else if (!enq_ok) begin
                res_status_q <= drr_pkg::ST_DROP_FULL;
              end else begin
                res_status_q <= drr_pkg::ST_ENQUEUED;
                cnt_q[efl]   <= cnt_q[efl] + drr_pkg::CW'(1);
              end
            end else begin
              p_q     <= '0;
              f_q     <= start_flow;
              found_q <= 1'b0;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN, S_DIV: begin
          if (div_start) begin
            state_q <= S_DIV;
          end else if (scan_adv) begin
            found_q <= found_n;
            if (p_q == n_last) begin
              p_q <= '0;
              f_q <= start_flow;
              if (found_n) begin
                state_q <= S_UPD;
              end else begin
                res_status_q <= drr_pkg::ST_NOTHING;
                state_q      <= S_DONE;
              end
            end else begin
              p_q     <= p_q + FW'(1);
              f_q     <= f_next;
              state_q <= S_SCAN;
            end
          end
        end
        S_UPD, S_ADD: begin
          if (state_q == S_UPD && cur_cnt != '0) begin
            prod_q  <= visits * cur_gain;
            state_q <= S_ADD;
          end else begin
            def_q[f_q] <= (state_q == S_ADD) ? drr_pkg::sat_add(cur_def, prod_q) : '0;
            if (p_q == n_last) begin
              state_q <= S_READ;
            end else begin
              p_q     <= p_q + FW'(1);
              f_q     <= f_next;
              state_q <= S_UPD;
            end
          end
        end
        S_READ: begin
          state_q <= S_SUB;
        end
        S_SUB: begin
          def_q[win_q]  <= drr_pkg::sat_sub(def_q[win_q], rd_q);
          head_q[win_q] <= (head_q[win_q] == drr_pkg::QW'(drr_pkg::QUEUE_DEPTH - 1))
                         ? '0 : head_q[win_q] + drr_pkg::QW'(1);
          cnt_q[win_q]  <= cnt_q[win_q] - drr_pkg::CW'(1);
          last_q        <= win_q;
          res_status_q  <= drr_pkg::ST_DEQUEUED;
          res_flow_q    <= 2'(win_q);
          res_size_q    <= rd_q;
          state_q       <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_flow_q   <= res_flow_q;
            out_size_q   <= res_size_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign served_flow_o = out_flow_q;
  assign served_size_o = out_size_q;

`ifndef SYNTHESIS
  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside of its wait state");

  // An accepted item always starts work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted item did not start");

  // Charging the winner always yields a dequeue result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUB) |=> (res_status_q == drr_pkg::ST_DEQUEUED))
    else $error("charge step left a wrong status");
`endif

endmodule
`default_nettype wire

### hdl/drr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drr_div: shared restoring divider
// Divides a 32-bit dividend by a gain, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module drr_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [31:0]            dividend_i,
  input  wire logic [drr_pkg::GW-1:0] divisor_i,
  output logic                        done_o,
  output logic [drr_pkg::KW-1:0]      quotient_o
);

  localparam int SW = $clog2(drr_pkg::DIV_STEPS + 1);

  logic [SW-1:0]            steps_q;
  logic                     done_q;
  logic [31:0]              dvd_q;
  logic [31:0]              quo_q;
  logic [drr_pkg::GW-1:0]   rem_q;
  logic [drr_pkg::GW-1:0]   dsr_q;
  logic [drr_pkg::GW:0]     rem_sh;
  logic                     ge;

  assign rem_sh = {rem_q, dvd_q[31]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        steps_q <= SW'(drr_pkg::DIV_STEPS);
      end else if (steps_q != '0) begin
        steps_q <= steps_q - SW'(1);
        done_q  <= (steps_q == SW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (steps_q != '0) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      quo_q <= {quo_q[30:0], ge};
      rem_q <= ge ? drr_pkg::GW'(rem_sh - {1'b0, dsr_q}) : rem_sh[drr_pkg::GW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[drr_pkg::KW-1:0];

endmodule
`default_nettype wire

### verif/drr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_checker: scoreboard of the deficit round robin scheduler
// Tracks configuration writes and accepted items, predicts every result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module drr_checker (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_stall_i,
  input  wire logic                   operation_i,
  input  wire logic [3:0]             flow_id_i,
  input  wire logic [15:0]            packet_size_i,
  input  wire logic                   out_valid_i,
  input  wire logic                   out_stall_i,
  input  wire logic [2:0]             status_i,
  input  wire logic [1:0]             served_flow_i,
  input  wire logic [15:0]            served_size_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [drr_pkg::IW-1:0] cfg_index_i,
  input  wire logic [15:0]            cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  flow;
    logic [15:0] size;
  } drr_result_t;

  drr_result_t   expected_q[$];
  logic [15:0]   size_mem[0:drr_pkg::MEM_DEPTH-1];
  int            head_ptr[drr_pkg::NUM_FLOWS];
  int            queue_len[drr_pkg::NUM_FLOWS];
  longint        deficit[drr_pkg::NUM_FLOWS];
  int            last_flow;
  logic [2:0]    active_reg;
  logic [15:0]   quantum_reg[drr_pkg::NUM_FLOWS];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint visit_gain(input int f);
    longint q;
    q = quantum_reg[f];
    if (q == 0) q = 1;
    return q * drr_pkg::QUANTUM_SCALE;
  endfunction

  // Applies one item to the tracked state and returns the result it causes.
  function automatic drr_result_t schedule(input logic op, input logic [3:0] fid,
                                           input logic [15:0] psize);
    drr_result_t r;
    int n, start, f, win, winpos, slot;
    longint best, k, visits;
    bit found;
    r = '0;
    n = active_reg;
    if (n < 1) n = 1;
    if (n > drr_pkg::NUM_FLOWS) n = drr_pkg::NUM_FLOWS;
    if (op == drr_pkg::OP_ENQUEUE) begin
      if (fid >= n) begin
        r.status = drr_pkg::ST_DROP_UNCL;
      end else if (queue_len[fid] >= drr_pkg::QUEUE_DEPTH) begin
        r.status = drr_pkg::ST_DROP_FULL;
      end else begin
        slot = (head_ptr[fid] + queue_len[fid]) % drr_pkg::QUEUE_DEPTH;
        size_mem[fid * drr_pkg::QUEUE_DEPTH + slot] = psize;
        queue_len[fid]++;
        r.status = drr_pkg::ST_ENQUEUED;
      end
      return r;
    end
    start = (last_flow + 1) % n;
    found = 0;
    best = 0;
    win = 0;
    winpos = 0;
    // The flow needing the fewest visits wins; ties go to the earliest in the walk.
    for (int p = 0; p < n; p++) begin
      f = (start + p) % n;
      if (queue_len[f] > 0) begin
        k = (deficit[f] > 0) ? 1 : (-deficit[f]) / visit_gain(f) + 1;
        if (!found || k < best) begin
          best = k;
          win = f;
          winpos = p;
          found = 1;
        end
      end
    end
    if (!found) begin
      r.status = drr_pkg::ST_NOTHING;
      return r;
    end
    for (int p = 0; p < n; p++) begin
      f = (start + p) % n;
      if (queue_len[f] == 0) begin
        deficit[f] = 0;
      end else begin
        visits = (p <= winpos) ? best : best - 1;
        deficit[f] = clamp32(deficit[f] + visits * visit_gain(f));
      end
    end
    r.size = size_mem[win * drr_pkg::QUEUE_DEPTH + head_ptr[win]];
    head_ptr[win] = (head_ptr[win] + 1) % drr_pkg::QUEUE_DEPTH;
    queue_len[win]--;
    deficit[win] = clamp32(deficit[win] - r.size);
    last_flow = win;
    r.flow = win[1:0];
    r.status = drr_pkg::ST_DEQUEUED;
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    drr_result_t want;
    if (!rst_ni) begin
      expected_q.delete();
      for (int i = 0; i < drr_pkg::NUM_FLOWS; i++) begin
        head_ptr[i] = 0;
        queue_len[i] = 0;
        deficit[i] = 0;
        quantum_reg[i] = 16'd1024;
      end
      last_flow = 0;
      active_reg = 3'd4;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected item status=%0d flow=%0d size=%0d", $realtime,
                     status_i, served_flow_i, served_size_i);
        end else begin
          want = expected_q.pop_front();
          if (want.status !== status_i || want.flow !== served_flow_i ||
              want.size !== served_size_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch expected %0d/%0d/%0d got %0d/%0d/%0d", $realtime,
                       want.status, want.flow, want.size,
                       status_i, served_flow_i, served_size_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(schedule(operation_i, flow_id_i, packet_size_i));
      if (cfg_we_i) begin
        if (cfg_index_i == drr_pkg::CFG_ACTIVE) active_reg = cfg_data_i[2:0];
        else if (cfg_index_i >= drr_pkg::CFG_QUANT0 &&
                 cfg_index_i < drr_pkg::CFG_QUANT0 + drr_pkg::NUM_FLOWS)
          quantum_reg[cfg_index_i - drr_pkg::CFG_QUANT0] = cfg_data_i;
      end
    end
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the deficit round robin scheduler
// Drives directed and random enqueue and dequeue items through several
// register settings with random idling on both sides; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  // A dequeue request carries the opposite operation code of an enqueue.
  localparam logic OP_DEQUEUE = ~drr_pkg::OP_ENQUEUE;
  // Idle time after a drain, longer than the longest dequeue.
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_ITEMS   = 138;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    operation_i = drr_pkg::OP_ENQUEUE;
  logic [3:0]              flow_id_i = '0;
  logic [15:0]             packet_size_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [2:0]              status_o;
  logic [1:0]              served_flow_o;
  logic [15:0]             served_size_o;
  logic                    cfg_we_i = 1'b0;
  logic [drr_pkg::IW-1:0]  cfg_index_i = drr_pkg::CFG_ACTIVE;
  logic [15:0]             cfg_data_i = '0;

  int  fail_count;
  int  pending;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  no_idle = 0;
  // Handshake flags registered at the rising edge and read at the falling one.
  bit  in_taken = 0;
  bit  out_taken = 0;

  always #10 clk_i = ~clk_i;

  deficit_round_robin_scheduler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .flow_id_i     (flow_id_i),
    .packet_size_i (packet_size_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .served_flow_o (served_flow_o),
    .served_size_o (served_size_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  drr_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .operation_i   (operation_i),
    .flow_id_i     (flow_id_i),
    .packet_size_i (packet_size_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status_o),
    .served_flow_i (served_flow_o),
    .served_size_i (served_size_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    in_taken  <= in_valid_i && !in_stall_o;
    out_taken <= out_valid_o && !out_stall_i;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiver stalls for a freshly drawn number of cycles after each item
  // it takes, so the stall lands on every phase of a dequeue walk.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (out_taken) stall_left = no_idle ? 0 : $urandom_range(0, 18);
    end
  end

  // Presents one item after a random gap and returns at the falling edge
  // that follows its acceptance; valid stays high when the next gap is zero.
  task automatic send_item(input logic op, input logic [3:0] fid,
                           input logic [15:0] psize);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i   = op;
    flow_id_i     = fid;
    packet_size_i = psize;
    in_valid_i    = 1'b1;
    do @(negedge clk_i); while (!in_taken);
  endtask

  // Drains all outstanding results so that registers change only when idle.
  task automatic drain;
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [drr_pkg::IW-1:0] idx, input logic [15:0] value);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [15:0] pick_size;
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 64));
      1: return 16'($urandom_range(65000, 65535));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  logic [15:0] settings[NUM_PHASES][drr_pkg::NUM_CFG];
  int          used;

  initial begin
    // Extremes first, then mixed and fully random settings. Active counts of
    // zero and seven act as one and four.
    settings[0] = '{16'd1, 16'd1, 16'd65535, 16'd65535, 16'd65535};
    settings[1] = '{16'd4, 16'd1, 16'd1, 16'd65535, 16'd300};
    settings[2] = '{16'd0, 16'd0, 16'd5, 16'd65535, 16'd1};
    settings[3] = '{16'd7, 16'd65535, 16'd65535, 16'd65535, 16'd65535};
    for (int p = 4; p < NUM_PHASES; p++) begin
      settings[p][0] = 16'($urandom_range(2, 3));
      for (int q = 1; q < drr_pkg::NUM_CFG; q++)
        settings[p][q] = 16'($urandom_range(0, 65535));
    end

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part under the reset settings: a dequeue with nothing queued,
    // size extremes including zero, unclassified flows and per-flow service.
    send_item(OP_DEQUEUE, 4'd15, 16'hffff);
    send_item(drr_pkg::OP_ENQUEUE, 4'd0, 16'd1);
    send_item(drr_pkg::OP_ENQUEUE, 4'd0, 16'd65535);
    send_item(drr_pkg::OP_ENQUEUE, 4'd0, 16'd0);
    send_item(drr_pkg::OP_ENQUEUE, 4'd1, 16'd1500);
    send_item(drr_pkg::OP_ENQUEUE, 4'd3, 16'd65535);
    send_item(drr_pkg::OP_ENQUEUE, 4'd4, 16'd100);
    send_item(drr_pkg::OP_ENQUEUE, 4'd15, 16'd65535);
    send_item(drr_pkg::OP_ENQUEUE, 4'd2, 16'h5555);
    send_item(drr_pkg::OP_ENQUEUE, 4'd2, 16'haaaa);
    for (int i = 0; i < 8; i++) send_item(OP_DEQUEUE, 4'(i), 16'(i * 77));
    // Leave packets in flow 3, which the next setting no longer serves.
    send_item(drr_pkg::OP_ENQUEUE, 4'd3, 16'd40000);
    send_item(drr_pkg::OP_ENQUEUE, 4'd3, 16'd20);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      for (int q = 0; q < drr_pkg::NUM_CFG; q++)
        write_reg(drr_pkg::IW'(q), settings[p][q]);
      used = settings[p][0];
      if (used < 1) used = 1;
      if (used > drr_pkg::NUM_FLOWS) used = drr_pkg::NUM_FLOWS;
      // Every other phase fills one flow past its depth to hit the full drop.
      if (p % 2 == 0) begin
        for (int i = 0; i < drr_pkg::QUEUE_DEPTH + 3; i++)
          send_item(drr_pkg::OP_ENQUEUE, 4'(p % used), pick_size());
      end
      for (int i = 0; i < PHASE_ITEMS - ((p % 2 == 0) ? drr_pkg::QUEUE_DEPTH + 3 : 0);
           i++) begin
        if (i % 30 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 52) begin
          send_item(drr_pkg::OP_ENQUEUE,
                    ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(0, used - 1)),
                    pick_size());
        end else begin
          send_item(OP_DEQUEUE, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
        end
      end
      no_idle = 0;
    end

    drain();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
